// ===== hw/rtl/mrm4_pkg.sv =====
// Shared types and constants for the 4x4 row-times-matrix block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mrm4_pkg;

    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_ELEM_WIDTH = 32;

    // Matrix order: elements per row, one lane per product column.
    localparam int LANES = 4;
    localparam int ROW_W = 2;
    localparam int ADDR_W = 2 * ROW_W;

    // Request kinds carried in tuser.
    localparam logic REQ_MULTIPLY = 1'b0;
    localparam logic REQ_LOAD     = 1'b1;

    // Control that travels down the pipeline beside the lane data.
    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
    } pipe_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/matrix_row_times_matrix_4x4.sv =====
// Top level of the 4x4 fixed-point row-times-matrix block: stream ports,
// right-matrix storage, four column lanes and the merging output stage.
// Depends on mrm4_pkg, mrm4_lane and mrm4_merge.
//
//  channel  | direction | handshake               | tdata / tuser
//  ---------+-----------+-------------------------+-----------------------------------
//  s_axis   | in        | s_axis_tvalid/_tready   | row_index, elem_0..3 / req_type
//  m_axis   | out       | m_axis_tvalid/_tready   | out_row, res_0..3 / saturated
//
// One request per cycle is taken while s_axis_tready is high; a multiply result passes
// through the partial-product, product-assembly, column-sum and output registers in turn.
// A load request writes one row of B at its accepting edge and returns nothing; a
// multiply in the very next cycle already sees that row.
// Reset clears B to zeros and empties the pipeline.
// When the result register is full and not taken, the whole pipeline holds and
// s_axis_tready drops; s_axis_tready = !m_axis_tvalid || m_axis_tready.
`default_nettype none

module matrix_row_times_matrix_4x4 #(
    parameter int FRAC_BITS  = mrm4_pkg::DEF_FRAC_BITS,
    parameter int ELEM_WIDTH = mrm4_pkg::DEF_ELEM_WIDTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // row_index [1:0], elem_0, elem_1, elem_2, elem_3, then zero fill
    input  wire logic [((mrm4_pkg::ROW_W + mrm4_pkg::LANES * ELEM_WIDTH + 7) / 8) * 8 - 1:0]
                      s_axis_tdata,
    // req_type
    input  wire logic s_axis_tuser,

    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // out_row [1:0], res_0, res_1, res_2, res_3, then zero fill
    output logic [((mrm4_pkg::ROW_W + mrm4_pkg::LANES * ELEM_WIDTH + 7) / 8) * 8 - 1:0]
                      m_axis_tdata,
    // saturated
    output logic      m_axis_tuser
);
    import mrm4_pkg::*;

    localparam int DEPTH = LANES * LANES;

    logic [ELEM_WIDTH-1:0] b_reg [DEPTH];

    logic [ELEM_WIDTH-1:0] in_elem [LANES];
    logic [ROW_W-1:0]      in_row;
    logic                  en;
    logic                  accept;
    logic                  load_req;
    logic                  mul_req;

    pipe_ctl_t ctl1_reg;
    pipe_ctl_t ctl2_reg;
    pipe_ctl_t ctl3_reg;

    logic [ELEM_WIDTH-1:0] lane_res  [LANES];
    logic [LANES-1:0]      lane_clip;

    // Unpack the request fields.
    assign in_row = s_axis_tdata[ROW_W-1:0];
    for (genvar k = 0; k < LANES; k++) begin : g_unpack
        assign in_elem[k] = s_axis_tdata[ROW_W + k*ELEM_WIDTH +: ELEM_WIDTH];
    end

    // Advance everything whenever the result register can take a new value.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;
    assign load_req      = accept && (s_axis_tuser == REQ_LOAD);
    assign mul_req       = accept && (s_axis_tuser == REQ_MULTIPLY);

    // Right matrix, row-major; a load overwrites one whole row.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                b_reg[i] <= '0;
            end
        end else if (load_req) begin
            for (int k = 0; k < LANES; k++) begin
                b_reg[{in_row, ROW_W'(k)}] <= in_elem[k];
            end
        end
    end

    // Valid and row number follow the lane data stage by stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg.valid <= 1'b0;
            ctl2_reg.valid <= 1'b0;
            ctl3_reg.valid <= 1'b0;
        end else if (en) begin
            ctl1_reg.valid <= mul_req;
            ctl2_reg.valid <= ctl1_reg.valid;
            ctl3_reg.valid <= ctl2_reg.valid;
            ctl1_reg.row   <= in_row;
            ctl2_reg.row   <= ctl1_reg.row;
            ctl3_reg.row   <= ctl2_reg.row;
        end
    end

    // One lane per product column; lane j reads column j of B.
    for (genvar j = 0; j < LANES; j++) begin : g_lane
        logic [ELEM_WIDTH-1:0] col [LANES];

        for (genvar k = 0; k < LANES; k++) begin : g_col
            assign col[k] = b_reg[{ROW_W'(k), ROW_W'(j)}];
        end

        mrm4_lane #(
            .FRAC_BITS  (FRAC_BITS),
            .ELEM_WIDTH (ELEM_WIDTH)
        ) u_lane (
            .aclk (aclk),
            .en   (en),
            .a    (in_elem),
            .b    (col),
            .res  (lane_res[j]),
            .clip (lane_clip[j])
        );
    end

    mrm4_merge #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .ctl       (ctl3_reg),
        .lane_res  (lane_res),
        .lane_clip (lane_clip),
        .m_valid   (m_axis_tvalid),
        .m_data    (m_axis_tdata),
        .m_flag    (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/mrm4_lane.sv =====
// One product column: four signed products split into half-width partial products,
// assembled, summed, then shifted and saturated. Depends on mrm4_pkg.
`default_nettype none

module mrm4_lane #(
    parameter int FRAC_BITS  = mrm4_pkg::DEF_FRAC_BITS,
    parameter int ELEM_WIDTH = mrm4_pkg::DEF_ELEM_WIDTH
) (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic [ELEM_WIDTH-1:0]        a [mrm4_pkg::LANES],
    input  wire logic [ELEM_WIDTH-1:0]        b [mrm4_pkg::LANES],
    output logic      [ELEM_WIDTH-1:0]        res,
    output logic                              clip
);
    import mrm4_pkg::*;

    localparam int LO_W   = (ELEM_WIDTH + 1) / 2;
    localparam int HI_W   = ELEM_WIDTH - LO_W;
    localparam int MID_W  = ELEM_WIDTH + 1;
    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int SUM_W  = PROD_W + 2;

    logic        [2*LO_W-1:0] pll_reg [LANES];
    logic signed [MID_W-1:0]  plh_reg [LANES];
    logic signed [MID_W-1:0]  phl_reg [LANES];
    logic signed [2*HI_W-1:0] phh_reg [LANES];

    logic [PROD_W-1:0] prod_next [LANES];
    logic [PROD_W-1:0] prod_reg  [LANES];

    logic        [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] shifted;
    logic                    fits;

    // Stage 1: partial products, low half unsigned, high half signed.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < LANES; k++) begin
                pll_reg[k] <= a[k][LO_W-1:0] * b[k][LO_W-1:0];
                plh_reg[k] <= $signed({1'b0, a[k][LO_W-1:0]}) *
                              $signed(b[k][ELEM_WIDTH-1:LO_W]);
                phl_reg[k] <= $signed(a[k][ELEM_WIDTH-1:LO_W]) *
                              $signed({1'b0, b[k][LO_W-1:0]});
                phh_reg[k] <= $signed(a[k][ELEM_WIDTH-1:LO_W]) *
                              $signed(b[k][ELEM_WIDTH-1:LO_W]);
            end
        end
    end

    // Stage 2: assemble each full-width product from its partials.
    for (genvar k = 0; k < LANES; k++) begin : g_prod
        logic [PROD_W-1:0] hh_ext;
        logic [PROD_W-1:0] mid_ext;
        logic [PROD_W-1:0] ll_ext;

        assign hh_ext  = {{(2*LO_W){phh_reg[k][2*HI_W-1]}}, phh_reg[k]} << (2 * LO_W);
        assign mid_ext = ({{(PROD_W-MID_W){plh_reg[k][MID_W-1]}}, plh_reg[k]}
                        + {{(PROD_W-MID_W){phl_reg[k][MID_W-1]}}, phl_reg[k]}) << LO_W;
        assign ll_ext  = {{(2*HI_W){1'b0}}, pll_reg[k]};
        assign prod_next[k] = hh_ext + mid_ext + ll_ext;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < LANES; k++) begin
                prod_reg[k] <= prod_next[k];
            end
        end
    end

    // Stage 3: exact column sum with two guard bits.
    always_comb begin
        sum_next = '0;
        for (int k = 0; k < LANES; k++) begin
            sum_next = sum_next + {{2{prod_reg[k][PROD_W-1]}}, prod_reg[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
        end
    end

    // Drop fraction bits (floor), then clip to the element range.
    assign shifted = sum_reg >>> FRAC_BITS;
    assign fits    = (&shifted[SUM_W-1:ELEM_WIDTH-1]) || !(|shifted[SUM_W-1:ELEM_WIDTH-1]);
    assign clip    = !fits;

    always_comb begin
        if (fits) begin
            res = shifted[ELEM_WIDTH-1:0];
        end else if (shifted[SUM_W-1]) begin
            res = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
        end else begin
            res = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mrm4_merge.sv =====
// Output stage: merges the four lane results and clip flags into one result
// register that drives the master stream. Depends on mrm4_pkg.
`default_nettype none

module mrm4_merge #(
    parameter int ELEM_WIDTH = mrm4_pkg::DEF_ELEM_WIDTH
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire mrm4_pkg::pipe_ctl_t        ctl,
    input  wire logic [ELEM_WIDTH-1:0]      lane_res [mrm4_pkg::LANES],
    input  wire logic [mrm4_pkg::LANES-1:0] lane_clip,
    output logic                            m_valid,
    output logic [((mrm4_pkg::ROW_W + mrm4_pkg::LANES * ELEM_WIDTH + 7) / 8) * 8 - 1:0]
                                            m_data,
    output logic                            m_flag
);
    import mrm4_pkg::*;

    localparam int DATA_W = ((ROW_W + LANES * ELEM_WIDTH + 7) / 8) * 8;
    localparam int PAD_W  = DATA_W - ROW_W - LANES * ELEM_WIDTH;

    logic              valid_reg;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              flag_reg;

    always_comb begin
        data_next = '0;
        data_next[ROW_W-1:0] = ctl.row;
        for (int j = 0; j < LANES; j++) begin
            data_next[ROW_W + j*ELEM_WIDTH +: ELEM_WIDTH] = lane_res[j];
        end
        data_next[DATA_W-1 -: PAD_W] = {PAD_W{1'b0}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
            flag_reg <= |lane_clip;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;
    assign m_flag  = flag_reg;

endmodule

`default_nettype wire
